// File: sv/p2a16_pkg.sv
// ----------------------------------------------------------------------------
// p2a16_pkg
// Shared types, register indexes and constant tables for the palette
// to ARGB16 converter.
// ----------------------------------------------------------------------------
package p2a16_pkg;

	typedef logic [2:0] reg_index_t;

	localparam reg_index_t REG_ADDITIVE   = 3'd0;
	localparam reg_index_t REG_MODULATION = 3'd1;
	localparam reg_index_t REG_COLOR_KEY  = 3'd2;
	localparam reg_index_t REG_NO_SCALE   = 3'd3;
	localparam reg_index_t REG_MAX_RED    = 3'd4;
	localparam reg_index_t REG_MAX_GREEN  = 3'd5;
	localparam reg_index_t REG_MAX_BLUE   = 3'd6;

	localparam int RECIP_SHIFT = 28;

	typedef logic [23:0] scale_t;
	typedef logic [26:0] recip_t;
	typedef scale_t scale_tbl_t [256];
	typedef recip_t recip_tbl_t [256];

	// shift and subtract quotient, used only to build the tables
	function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
			r = {r[62:0], n[bit_pos]};
			if (r >= d) begin
				r = r - d;
				q[bit_pos] = 1'b1;
			end
		end
		return q;
	endfunction

	// 0x10000*255 / max, for max = 1..255; entry 0 unused (max is raised to 1)
	function automatic scale_tbl_t build_scale_tbl();
		scale_tbl_t t;
		t[0] = scale_t'(24'hFF0000);
		for (int i = 1; i < 256; i++) begin
			t[i] = scale_t'(const_udiv(64'hFF0000, 64'(i)));
		end
		return t;
	endfunction

	// floor(2^28 / (3*(I+1))) for intensity I
	function automatic recip_tbl_t build_recip_tbl();
		recip_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = recip_t'(const_udiv(64'd1 << RECIP_SHIFT, 64'(3 * (i + 1))));
		end
		return t;
	endfunction

	localparam scale_tbl_t SCALE_TBL = build_scale_tbl();
	localparam recip_tbl_t RECIP_TBL = build_recip_tbl();

endpackage

// File: sv/palette_to_argb16_converter.sv
// ----------------------------------------------------------------------------
// palette_to_argb16_converter
// Converts one RGB palette entry into a 16-bit texel per transfer.
// ----------------------------------------------------------------------------
// Source channel: src_valid/src_stall with entry_index, red, green, blue.
// Result channel: res_valid/res_stall with texel.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// write only while no entry is in flight.
// Five register stages: stages 1 to 4 and the output register. One entry per
// cycle is sustained while res_stall does not hold a valid result; the intensity division is done
// by a reciprocal multiply (stage 2) with a one-step correction (stage 3),
// then scaled in stage 4 and packed into the output register.
// While res_stall holds a valid result the whole pipeline freezes and
// src_stall is raised; nothing is dropped or repeated.
// Reset empties the pipeline and restores the mode bits to 0 and the
// channel maxima to 255.
// ----------------------------------------------------------------------------
module palette_to_argb16_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [15:0] texel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic       add_q, mod_q, key_q, nos_q;
	logic [7:0] maxr_q, maxg_q, maxb_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_q  <= 1'b0;
			mod_q  <= 1'b0;
			key_q  <= 1'b0;
			nos_q  <= 1'b0;
			maxr_q <= 8'hFF;
			maxg_q <= 8'hFF;
			maxb_q <= 8'hFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				p2a16_pkg::REG_ADDITIVE:   add_q  <= cfg_data[0];
				p2a16_pkg::REG_MODULATION: mod_q  <= cfg_data[0];
				p2a16_pkg::REG_COLOR_KEY:  key_q  <= cfg_data[0];
				p2a16_pkg::REG_NO_SCALE:   nos_q  <= cfg_data[0];
				p2a16_pkg::REG_MAX_RED:    maxr_q <= cfg_data;
				p2a16_pkg::REG_MAX_GREEN:  maxg_q <= cfg_data;
				p2a16_pkg::REG_MAX_BLUE:   maxb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [7:0] eff_max(input logic nos, input logic [7:0] mx);
		logic [7:0] m;
		m = nos ? 8'hFF : mx;
		return (m == 8'd0) ? 8'd1 : m;
	endfunction

	logic [23:0] sr, sg, sb;
	assign sr = p2a16_pkg::SCALE_TBL[eff_max(nos_q, maxr_q)];
	assign sg = p2a16_pkg::SCALE_TBL[eff_max(nos_q, maxg_q)];
	assign sb = p2a16_pkg::SCALE_TBL[eff_max(nos_q, maxb_q)];

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	assign en        = !(res_valid && res_stall);
	assign src_stall = !en;

	// stage 1: intensity, numerators, reciprocal
	logic [7:0]  inten;
	logic [9:0]  k;
	assign inten = (red > green) ? ((red > blue) ? red : blue)
	                             : ((green > blue) ? green : blue);
	assign k = {1'b0, inten, 1'b0} + 10'd258;

	logic        idx0_s1;
	logic [7:0]  r_s1, g_s1, b_s1, i_s1;
	logic [17:0] nr_s1, ng_s1, nb_s1;
	logic [26:0] m_s1;
	logic [9:0]  d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= src_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			idx0_s1 <= (entry_index == 8'd0);
			r_s1    <= red;
			g_s1    <= green;
			b_s1    <= blue;
			i_s1    <= inten;
			nr_s1   <= 18'(red * k);
			ng_s1   <= 18'(green * k);
			nb_s1   <= 18'(blue * k);
			m_s1    <= p2a16_pkg::RECIP_TBL[inten];
			d_s1    <= 10'({2'b00, inten} * 10'd3 + 10'd3);
		end
	end

	// stage 2: quotient estimate
	logic [44:0] pr2, pg2, pb2;
	assign pr2 = nr_s1 * m_s1;
	assign pg2 = ng_s1 * m_s1;
	assign pb2 = nb_s1 * m_s1;

	logic        idx0_s2;
	logic [7:0]  r_s2, g_s2, b_s2, i_s2, qr_s2, qg_s2, qb_s2;
	logic [17:0] nr_s2, ng_s2, nb_s2;
	logic [9:0]  d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			idx0_s2 <= idx0_s1;
			r_s2    <= r_s1;
			g_s2    <= g_s1;
			b_s2    <= b_s1;
			i_s2    <= i_s1;
			nr_s2   <= nr_s1;
			ng_s2   <= ng_s1;
			nb_s2   <= nb_s1;
			d_s2    <= d_s1;
			qr_s2   <= pr2[p2a16_pkg::RECIP_SHIFT +: 8];
			qg_s2   <= pg2[p2a16_pkg::RECIP_SHIFT +: 8];
			qb_s2   <= pb2[p2a16_pkg::RECIP_SHIFT +: 8];
		end
	end

	// stage 3: correction, plain channel products
	function automatic logic [7:0] fix_q(input logic [7:0] q, input logic [17:0] n,
	                                     input logic [9:0] d);
		logic [17:0] rem;
		rem = n - 18'(q * d);
		return (rem >= {8'd0, d}) ? 8'(q + 8'd1) : q;
	endfunction

	logic        idx0_s3;
	logic [7:0]  i_s3, r_s3, g_s3, b_s3, qr_s3, qg_s3, qb_s3;
	logic [31:0] pr_s3, pg_s3, pb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			idx0_s3 <= idx0_s2;
			i_s3    <= i_s2;
			r_s3    <= r_s2;
			g_s3    <= g_s2;
			b_s3    <= b_s2;
			qr_s3   <= fix_q(qr_s2, nr_s2, d_s2);
			qg_s3   <= fix_q(qg_s2, ng_s2, d_s2);
			qb_s3   <= fix_q(qb_s2, nb_s2, d_s2);
			pr_s3   <= 32'(r_s2 * sr);
			pg_s3   <= 32'(g_s2 * sg);
			pb_s3   <= 32'(b_s2 * sb);
		end
	end

	// stage 4: additive scaling
	logic        idx0_s4;
	logic [7:0]  i_s4, r_s4, g_s4, b_s4;
	logic [31:0] pr_s4, pg_s4, pb_s4, vr_s4, vg_s4, vb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			idx0_s4 <= idx0_s3;
			i_s4    <= i_s3;
			r_s4    <= r_s3;
			g_s4    <= g_s3;
			b_s4    <= b_s3;
			pr_s4   <= pr_s3;
			pg_s4   <= pg_s3;
			pb_s4   <= pb_s3;
			vr_s4   <= 32'(qr_s3 * sr);
			vg_s4   <= 32'(qg_s3 * sg);
			vb_s4   <= 32'(qb_s3 * sb);
		end
	end

	// stage 5: packing into the output register
	logic [15:0] t;
	always_comb begin
		if (add_q) begin
			t = {~i_s4[7:4], vr_s4[23:20], vg_s4[23:20], vb_s4[23:20]};
		end else if (mod_q) begin
			t = {(i_s4[7] ? 4'hF : i_s4[6:3]), 12'd0};
		end else if (key_q) begin
			if (nos_q) t = {4'd0, r_s4[7:4], g_s4[7:4], b_s4[7:4]};
			else       t = {4'd0, pr_s4[23:20], pg_s4[23:20], pb_s4[23:20]};
		end else begin
			if (nos_q) t = {1'b0, r_s4[7:3], g_s4[7:3], b_s4[7:3]};
			else       t = {1'b0, pr_s4[23:19], pg_s4[23:19], pb_s4[23:19]};
		end
		if (key_q && idx0_s4) t[15:12] = 4'hF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (en) res_valid <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) texel <= t;
	end

endmodule

// File: bench/tb_palette_to_argb16_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_to_argb16_converter
// Streams palette entries through the converter under several mode and
// channel-maximum settings, predicts each texel and compares in order.
// ----------------------------------------------------------------------------
module tb_palette_to_argb16_converter;

	typedef struct packed {
		logic [7:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} entry_t;

	logic        clk;
	logic        arst_n;
	logic        src_valid;
	logic        src_stall;
	logic [7:0]  entry_index, red, green, blue;
	logic        res_valid;
	logic        res_stall;
	logic [15:0] texel;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	palette_to_argb16_converter dut (.*);

	entry_t      pending_entries[$];
	logic [15:0] expected_texels[$];
	int          mismatches = 0;
	int          src_idle_pct = 0;
	int          res_stall_pct = 0;
	logic        hold_start = 0;
	logic        hold_on = 0;
	logic        mode_add, mode_mod, mode_key, mode_noscale;
	logic [7:0]  mx_r, mx_g, mx_b;

	function automatic logic [31:0] chan_scale(logic [7:0] mx);
		logic [31:0] m;
		m = mode_noscale ? 32'd255 : {24'd0, mx};
		if (m < 1) m = 1;
		return 32'hFF0000 / m;
	endfunction

	function automatic logic [15:0] convert_entry(entry_t e);
		logic [31:0] sr, sg, sb, r, g, b, inten, top, bot, vr, vg, vb, t, i2;
		logic        key_alpha;
		sr = chan_scale(mx_r);
		sg = chan_scale(mx_g);
		sb = chan_scale(mx_b);
		r = e.r;
		g = e.g;
		b = e.b;
		inten = (r > g) ? r : g;
		if (b > inten) inten = b;
		key_alpha = 0;
		if (mode_add) begin
			top = 512 * inten + 66048;
			bot = (inten + 1) * 768;
			vr = (r * top / bot) * sr;
			vg = (g * top / bot) * sg;
			vb = (b * top / bot) * sb;
			t = ((vr & 32'hF00000) >> 12) | ((vg & 32'hF00000) >> 16)
				| ((vb & 32'hF00000) >> 20) | (((255 - inten) & 32'hF0) << 8);
			key_alpha = mode_key;
		end else if (mode_mod) begin
			i2 = inten * 2;
			if (i2 > 255) i2 = 255;
			t = (i2 & 32'hF0) << 8;
			key_alpha = mode_key;
		end else if (mode_key) begin
			if (mode_noscale)
				t = ((r & 32'hF0) << 4) + (g & 32'hF0) + ((b & 32'hF0) >> 4);
			else
				t = (((r * sr) & 32'hF00000) >> 12) | (((g * sg) & 32'hF00000) >> 16)
					| (((b * sb) & 32'hF00000) >> 20);
			key_alpha = 1;
		end else begin
			if (mode_noscale)
				t = ((r & 32'hF8) << 7) + ((g & 32'hF8) << 2) + ((b & 32'hF8) >> 3);
			else
				t = (((r * sr) & 32'hF80000) >> 9) | (((g * sg) & 32'hF80000) >> 14)
					| (((b * sb) & 32'hF80000) >> 19);
		end
		if (key_alpha && e.idx == 0) t = t | 32'hF000;
		return t[15:0];
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 0;
			entry_index <= 0;
			red <= 0;
			green <= 0;
			blue <= 0;
		end else if (!src_valid || !src_stall) begin
			if (src_valid) expected_texels.push_back(convert_entry({entry_index, red, green, blue}));
			if (pending_entries.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				entry_t e;
				e = pending_entries.pop_front();
				src_valid <= 1;
				{entry_index, red, green, blue} <= e;
			end else begin
				src_valid <= 0;
			end
		end
	end

	// long receiver hold, counted here
	initial begin
		wait (hold_start);
		@(posedge clk);
		hold_on <= 1;
		repeat (60) @(posedge clk);
		hold_on <= 0;
	end

	// monitor and result-side stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_texels.size() == 0) begin
					$error("texel: unexpected transfer, actual %h", texel);
					mismatches++;
				end else begin
					logic [15:0] want;
					want = expected_texels.pop_front();
					if (want !== texel) begin
						$error("texel: expected %h actual %h", want, texel);
						mismatches++;
					end
				end
			end
			res_stall <= hold_on || ($urandom_range(99) < res_stall_pct);
		end
	end

	task automatic write_reg(p2a16_pkg::reg_index_t i, logic [7:0] d);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= i;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (i)
			p2a16_pkg::REG_ADDITIVE:   mode_add = d[0];
			p2a16_pkg::REG_MODULATION: mode_mod = d[0];
			p2a16_pkg::REG_COLOR_KEY:  mode_key = d[0];
			p2a16_pkg::REG_NO_SCALE:   mode_noscale = d[0];
			p2a16_pkg::REG_MAX_RED:    mx_r = d;
			p2a16_pkg::REG_MAX_GREEN:  mx_g = d;
			p2a16_pkg::REG_MAX_BLUE:   mx_b = d;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_entries.size() > 0 || src_valid || expected_texels.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic configure(logic a, logic m, logic k, logic n,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		write_reg(p2a16_pkg::REG_ADDITIVE, {7'd0, a});
		write_reg(p2a16_pkg::REG_MODULATION, {7'd0, m});
		write_reg(p2a16_pkg::REG_COLOR_KEY, {7'd0, k});
		write_reg(p2a16_pkg::REG_NO_SCALE, {7'd0, n});
		write_reg(p2a16_pkg::REG_MAX_RED, r);
		write_reg(p2a16_pkg::REG_MAX_GREEN, g);
		write_reg(p2a16_pkg::REG_MAX_BLUE, b);
	endtask

	task automatic queue_random(int n);
		entry_t e;
		for (int i = 0; i < n; i++) begin
			e = $urandom;
			if ($urandom_range(7) == 0) e.idx = 0;
			pending_entries.push_back(e);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = p2a16_pkg::REG_ADDITIVE;
		cfg_data = 0;
		mode_add = 0; mode_mod = 0; mode_key = 0; mode_noscale = 0;
		mx_r = 255; mx_g = 255; mx_b = 255;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed: reset settings, then each mode
		for (int m = 0; m < 6; m++) begin
			case (m)
				1: configure(1, 0, 1, 0, 255, 255, 255);
				2: configure(0, 1, 1, 0, 0, 1, 255);
				3: configure(0, 0, 1, 1, 0, 0, 0);
				4: configure(0, 0, 0, 1, 128, 7, 200);
				5: configure(1, 1, 0, 0, 0, 255, 1);
				default: ;
			endcase
			pending_entries.push_back('{8'd0, 8'd255, 8'd255, 8'd255});
			pending_entries.push_back('{8'd255, 8'd0, 8'd0, 8'd0});
			pending_entries.push_back('{8'd0, 8'd127, 8'd128, 8'd1});
			pending_entries.push_back('{8'd1, 8'hAA, 8'h55, 8'hF0});
			drain();
		end
		// random phases: idle patterns and settings vary
		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: begin src_idle_pct = 0; res_stall_pct = 0; end
				1: begin src_idle_pct = 75; res_stall_pct = 0; end
				2: begin src_idle_pct = 0; res_stall_pct = 75; end
				default: begin src_idle_pct = 26; res_stall_pct = 26; end
			endcase
			if (p == 11)
				configure(0, 0, 0, 0, 255, 255, 255);
			else
				configure($urandom_range(3) == 0, $urandom_range(2) == 0,
					1'($urandom_range(1)), 1'($urandom_range(1)),
					$urandom_range(3) == 0 ? 8'd0 : 8'($urandom),
					8'($urandom), $urandom_range(3) == 0 ? 8'd255 : 8'($urandom));
			if (p == 5) begin
				src_idle_pct = 0;
				hold_start = 1;
			end
			queue_random(70);
			if (p == 7) begin
				// pause until everything is back, then go on
				drain();
				queue_random(10);
			end
			drain();
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
